### rtl/esp3_dfr_pkg.sv
// Package for the serial telegram deframer: role and status codes, limits,
// and the CRC-8 byte update. No dependencies.
package esp3_dfr_pkg;

    localparam int MAX_DATA = 1024;
    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 3;
    localparam int DL_W     = 11;
    localparam int CNT_W    = 11;
    localparam int HLEN_W   = 16;

    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;
    localparam logic [BYTE_W-1:0] SYNC_INIT = 8'h55;

    // byte roles
    localparam logic [CODE_W-1:0] ROLE_SKIP = 3'd0;
    localparam logic [CODE_W-1:0] ROLE_SYNC = 3'd1;
    localparam logic [CODE_W-1:0] ROLE_HDR  = 3'd2;
    localparam logic [CODE_W-1:0] ROLE_HCRC = 3'd3;
    localparam logic [CODE_W-1:0] ROLE_DATA = 3'd4;
    localparam logic [CODE_W-1:0] ROLE_OPT  = 3'd5;
    localparam logic [CODE_W-1:0] ROLE_DCRC = 3'd6;

    // status codes
    localparam logic [CODE_W-1:0] ST_BUSY    = 3'd0;
    localparam logic [CODE_W-1:0] ST_GOOD    = 3'd1;
    localparam logic [CODE_W-1:0] ST_NOSYNC  = 3'd2;
    localparam logic [CODE_W-1:0] ST_TOOLONG = 3'd3;
    localparam logic [CODE_W-1:0] ST_HCRC    = 3'd4;
    localparam logic [CODE_W-1:0] ST_DCRC    = 3'd5;

    // CRC-8, MSB first, one byte
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/esp3_telegram_deframer_unit.sv
// Serial telegram deframer top level: sync hunt, header and body tracking,
// header and data CRC-8 checks. Depends on esp3_dfr_pkg.

// Takes one received byte per transfer and returns one tagged result per byte
// (role, status, and the current telegram's type and lengths). A byte is
// taken every cycle unless the result is stalled, and passes through the
// input register, then the result register. The rate is set by the per-byte
// state update, whose longest path is the eight-step CRC-8 byte update
// feeding the running CRC register. The sync byte is the one configuration
// register (reset 0x55); write it only while no bytes are in flight. While
// the result is stalled the input register can still take one byte; after
// that the byte channel's ready stays low until the result is taken.
module esp3_telegram_deframer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rx_valid,
    output logic                                o_rx_ready,
    input  logic [esp3_dfr_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [esp3_dfr_pkg::BYTE_W-1:0]     i_cfg_sync_value,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [esp3_dfr_pkg::BYTE_W-1:0]     o_byte_out,
    output logic [esp3_dfr_pkg::CODE_W-1:0]     o_byte_role,
    output logic [esp3_dfr_pkg::CODE_W-1:0]     o_status,
    output logic [esp3_dfr_pkg::BYTE_W-1:0]     o_packet_type,
    output logic [esp3_dfr_pkg::DL_W-1:0]       o_data_length,
    output logic [esp3_dfr_pkg::BYTE_W-1:0]     o_option_length
);
    import esp3_dfr_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_HCRC   = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_DCRC   = 3'd4;

    localparam int BLEN_W = HLEN_W + 1;

    // input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // frame state
    logic [BYTE_W-1:0] r_sync;
    logic [2:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [HLEN_W-1:0] r_dlen, n_dlen;
    logic [BYTE_W-1:0] r_olen, n_olen;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_crc, n_crc;

    // result stage
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [CODE_W-1:0] r_out_role, n_role;
    logic [CODE_W-1:0] r_out_status, n_status;
    logic [BYTE_W-1:0] r_out_type;
    logic [DL_W-1:0]   r_out_dlen, n_dl_sat;
    logic [BYTE_W-1:0] r_out_olen;

    logic              adv;
    logic              step;
    logic [CNT_W-1:0]  cnt_inc;
    logic [BLEN_W-1:0] body_len;
    logic [BYTE_W-1:0] crc_next;

    assign adv        = !r_out_valid || i_res_ready;
    assign step       = r_in_valid && adv;
    assign o_rx_ready = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    assign cnt_inc  = r_count + CNT_W'(1);
    assign body_len = {1'b0, r_dlen} + BLEN_W'(r_olen);
    assign crc_next = crc8_update(r_crc, r_in_byte);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_dlen   = r_dlen;
        n_olen   = r_olen;
        n_type   = r_type;
        n_crc    = r_crc;
        n_role   = ROLE_SKIP;
        n_status = ST_BUSY;
        unique case (r_phase)
            PH_HEADER: begin
                n_role  = ROLE_HDR;
                n_crc   = crc_next;
                if (r_count == CNT_W'(0)) begin
                    n_dlen = {r_in_byte, 8'h00};
                end else if (r_count == CNT_W'(1)) begin
                    n_dlen = {r_dlen[HLEN_W-1:BYTE_W], r_in_byte};
                end else if (r_count == CNT_W'(2)) begin
                    n_olen = r_in_byte;
                end else begin
                    n_type = r_in_byte;
                end
                n_count = cnt_inc;
                if (cnt_inc >= CNT_W'(4)) begin
                    n_phase = PH_HCRC;
                end
            end
            PH_HCRC: begin
                n_role = ROLE_HCRC;
                if (r_dlen > HLEN_W'(MAX_DATA)) begin
                    n_status = ST_TOOLONG;
                    n_phase  = PH_HUNT;
                end else if (r_crc != r_in_byte) begin
                    n_status = ST_HCRC;
                    n_phase  = PH_HUNT;
                end else begin
                    n_crc   = '0;
                    n_count = '0;
                    n_phase = (body_len == '0) ? PH_DCRC : PH_BODY;
                end
            end
            PH_BODY: begin
                n_role  = (HLEN_W'(r_count) < r_dlen) ? ROLE_DATA : ROLE_OPT;
                n_crc   = crc_next;
                n_count = cnt_inc;
                if (BLEN_W'(cnt_inc) >= body_len) begin
                    n_phase = PH_DCRC;
                end
            end
            PH_DCRC: begin
                n_role   = ROLE_DCRC;
                n_status = (r_crc == r_in_byte) ? ST_GOOD : ST_DCRC;
                n_phase  = PH_HUNT;
            end
            default: begin
                // hunting; unused codes behave the same
                n_count = '0;
                n_dlen  = '0;
                n_olen  = '0;
                n_type  = '0;
                n_crc   = '0;
                if (r_in_byte == r_sync) begin
                    n_role  = ROLE_SYNC;
                    n_phase = PH_HEADER;
                end else begin
                    n_role   = ROLE_SKIP;
                    n_status = ST_NOSYNC;
                    n_phase  = PH_HUNT;
                end
            end
        endcase
        n_dl_sat = (n_dlen > HLEN_W'(MAX_DATA)) ? DL_W'(MAX_DATA) : n_dlen[DL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sync      <= SYNC_INIT;
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_dlen      <= '0;
            r_olen      <= '0;
            r_type      <= '0;
            r_crc       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_sync <= i_cfg_sync_value;
            end
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_dlen  <= n_dlen;
                r_olen  <= n_olen;
                r_type  <= n_type;
                r_crc   <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (step) begin
            r_out_byte   <= r_in_byte;
            r_out_role   <= n_role;
            r_out_status <= n_status;
            r_out_type   <= n_type;
            r_out_dlen   <= n_dl_sat;
            r_out_olen   <= n_olen;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_byte_out      = r_out_byte;
    assign o_byte_role     = r_out_role;
    assign o_status        = r_out_status;
    assign o_packet_type   = r_out_type;
    assign o_data_length   = r_out_dlen;
    assign o_option_length = r_out_olen;

`ifndef SYNTHESIS
    // any final status sends the frame logic back to hunting
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && n_status != ST_BUSY) |=> (r_phase == PH_HUNT))
        else $error("frame ended without returning to hunt");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_count < CNT_W'(4)))
        else $error("header byte count out of range");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (BLEN_W'(r_count) < body_len))
        else $error("body count past body length");

    a_body_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY || r_phase == PH_DCRC) |-> (r_dlen <= HLEN_W'(MAX_DATA)))
        else $error("oversized data length reached body");

    a_skip_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_role == ROLE_SKIP) |->
        (r_out_status == ST_NOSYNC && r_out_type == '0 && r_out_dlen == '0
         && r_out_olen == '0))
        else $error("skipped byte with stale header fields");
`endif

endmodule
